### src/time_of_day_adjust_unit_defines.svh
// assertion macros for the time-of-day adjust unit
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef TIME_OF_DAY_ADJUST_UNIT_DEFINES_SVH
`define TIME_OF_DAY_ADJUST_UNIT_DEFINES_SVH

// same-cycle implication
`define TDADJ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TDADJ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/tdadj_pkg.sv
// shared types and constants for the time-of-day adjust unit
// no dependencies
package tdadj_pkg;

  localparam int unsigned AmtW     = 17;
  localparam int unsigned HourW    = 5;
  localparam int unsigned MinW     = 6;
  localparam int unsigned SecW     = 6;
  localparam int unsigned QuoW     = 13;
  localparam int unsigned RecipW   = 30;
  localparam int unsigned DivShift = 34;
  localparam int unsigned ProdW    = AmtW + RecipW;
  localparam int unsigned RemW     = AmtW + QuoW;

  localparam logic [AmtW-1:0] SecPerDay   = 17'd86400;
  localparam logic [AmtW-1:0] MinPerDay   = 17'd1440;
  localparam logic [AmtW-1:0] HoursPerDay = 17'd24;
  localparam logic [AmtW-1:0] SecPerHour  = 17'd3600;
  localparam logic [AmtW-1:0] SecPerMin   = 17'd60;

  // reciprocals for exact constant division: q = (x * k) >> DivShift
  localparam logic [63:0] DivOne = 64'd1 << DivShift;
  localparam logic [RecipW-1:0] RecipSecDay =
    RecipW'((DivOne + 64'(SecPerDay) - 64'd1) / 64'(SecPerDay));
  localparam logic [RecipW-1:0] RecipMinDay =
    RecipW'((DivOne + 64'(MinPerDay) - 64'd1) / 64'(MinPerDay));
  localparam logic [RecipW-1:0] RecipHourDay =
    RecipW'((DivOne + 64'(HoursPerDay) - 64'd1) / 64'(HoursPerDay));
  localparam logic [RecipW-1:0] RecipSecHour =
    RecipW'((DivOne + 64'(SecPerHour) - 64'd1) / 64'(SecPerHour));
  localparam logic [RecipW-1:0] RecipSecMin =
    RecipW'((DivOne + 64'(SecPerMin) - 64'd1) / 64'(SecPerMin));

  localparam logic [SecW:0]  SecWrap  = 7'd60;
  localparam logic [MinW:0]  MinWrap  = 7'd60;
  localparam logic [HourW:0] HourWrap = 6'd24;

  typedef enum logic [1:0] {
    OpInc = 2'd0,
    OpDec = 2'd1,
    OpAdd = 2'd2,
    OpSub = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    UnitSec  = 2'd0,
    UnitMin  = 2'd1,
    UnitHour = 2'd2,
    UnitBad  = 2'd3
  } unit_e;

  typedef struct packed {
    op_e             operation;
    unit_e           unit;
    logic [AmtW-1:0] amount;
  } in_t;

  typedef struct packed {
    logic [HourW-1:0] hours_now;
    logic [MinW-1:0]  minutes_now;
    logic [SecW-1:0]  seconds_now;
    logic             bad_unit;
  } out_t;

  typedef struct packed {
    op_e              op;
    unit_e            unit;
    logic [AmtW-1:0]  x;
    logic [QuoW-1:0]  q;
    logic [HourW-1:0] dh;
    logic [MinW-1:0]  dm;
    logic [SecW-1:0]  ds;
  } pipe_t;

  typedef struct packed {
    op_e              op;
    unit_e            unit;
    logic [HourW-1:0] dh;
    logic [MinW-1:0]  dm;
    logic [SecW-1:0]  ds;
  } delta_t;

endpackage

### src/tdadj_split.sv
// amount decomposition pipeline: reduces the amount modulo one day and
// splits it into hour, minute and second deltas; uses tdadj_pkg
module tdadj_split (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tdadj_pkg::in_t    in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tdadj_pkg::delta_t out_o
);

  localparam int unsigned NumStg = 7;

  tdadj_pkg::pipe_t stg_q [NumStg];
  tdadj_pkg::pipe_t stg_d [NumStg];
  logic [NumStg-1:0] vld_q;
  logic [NumStg-1:0] vld_in;
  logic [NumStg:0]   adv;
  logic [tdadj_pkg::AmtW-1:0] ds_raw;

  function automatic logic [tdadj_pkg::QuoW-1:0] recip_quo(
    input logic [tdadj_pkg::AmtW-1:0]   x,
    input logic [tdadj_pkg::RecipW-1:0] k
  );
    logic [tdadj_pkg::ProdW-1:0] prod;
    prod = tdadj_pkg::ProdW'(x) * tdadj_pkg::ProdW'(k);
    return prod[tdadj_pkg::DivShift +: tdadj_pkg::QuoW];
  endfunction

  function automatic logic [tdadj_pkg::AmtW-1:0] quo_rem(
    input logic [tdadj_pkg::AmtW-1:0] x,
    input logic [tdadj_pkg::QuoW-1:0] q,
    input logic [tdadj_pkg::AmtW-1:0] d
  );
    logic [tdadj_pkg::RemW-1:0] prod;
    prod = tdadj_pkg::RemW'(q) * tdadj_pkg::RemW'(d);
    return x - prod[tdadj_pkg::AmtW-1:0];
  endfunction

  assign adv[NumStg] = out_ready_i;
  assign vld_in      = {vld_q[NumStg-2:0], in_valid_i};

  for (genvar i = 0; i < NumStg; i++) begin : g_stg
    assign adv[i] = !vld_q[i] || adv[i+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (adv[i]) begin
        vld_q[i] <= vld_in[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[i]) begin
        stg_q[i] <= stg_d[i];
      end
    end
  end

  always_comb begin
    // capture
    stg_d[0]      = '0;
    stg_d[0].op   = in_i.operation;
    stg_d[0].unit = in_i.unit;
    stg_d[0].x    = in_i.amount;

    // quotient by the day length in the chosen unit
    stg_d[1] = stg_q[0];
    case (stg_q[0].unit)
      tdadj_pkg::UnitSec: stg_d[1].q = recip_quo(stg_q[0].x, tdadj_pkg::RecipSecDay);
      tdadj_pkg::UnitMin: stg_d[1].q = recip_quo(stg_q[0].x, tdadj_pkg::RecipMinDay);
      default:            stg_d[1].q = recip_quo(stg_q[0].x, tdadj_pkg::RecipHourDay);
    endcase

    // amount within one day
    stg_d[2] = stg_q[1];
    case (stg_q[1].unit)
      tdadj_pkg::UnitSec: stg_d[2].x = quo_rem(stg_q[1].x, stg_q[1].q, tdadj_pkg::SecPerDay);
      tdadj_pkg::UnitMin: stg_d[2].x = quo_rem(stg_q[1].x, stg_q[1].q, tdadj_pkg::MinPerDay);
      default:            stg_d[2].x = quo_rem(stg_q[1].x, stg_q[1].q, tdadj_pkg::HoursPerDay);
    endcase

    // hour digit
    stg_d[3] = stg_q[2];
    if (stg_q[2].unit == tdadj_pkg::UnitSec) begin
      stg_d[3].q = recip_quo(stg_q[2].x, tdadj_pkg::RecipSecHour);
    end else begin
      stg_d[3].q = recip_quo(stg_q[2].x, tdadj_pkg::RecipSecMin);
    end

    stg_d[4] = stg_q[3];
    if (stg_q[3].unit == tdadj_pkg::UnitHour) begin
      stg_d[4].dh = stg_q[3].x[tdadj_pkg::HourW-1:0];
    end else begin
      stg_d[4].dh = stg_q[3].q[tdadj_pkg::HourW-1:0];
    end
    if (stg_q[3].unit == tdadj_pkg::UnitSec) begin
      stg_d[4].x = quo_rem(stg_q[3].x, stg_q[3].q, tdadj_pkg::SecPerHour);
    end else begin
      stg_d[4].x = quo_rem(stg_q[3].x, stg_q[3].q, tdadj_pkg::SecPerMin);
    end

    // minute and second digits
    stg_d[5]   = stg_q[4];
    stg_d[5].q = recip_quo(stg_q[4].x, tdadj_pkg::RecipSecMin);

    stg_d[6] = stg_q[5];
    ds_raw   = quo_rem(stg_q[5].x, stg_q[5].q, tdadj_pkg::SecPerMin);
    case (stg_q[5].unit)
      tdadj_pkg::UnitSec: begin
        stg_d[6].dm = stg_q[5].q[tdadj_pkg::MinW-1:0];
        stg_d[6].ds = ds_raw[tdadj_pkg::SecW-1:0];
      end
      tdadj_pkg::UnitMin: begin
        stg_d[6].dm = ds_raw[tdadj_pkg::MinW-1:0];
        stg_d[6].ds = '0;
      end
      default: begin
        stg_d[6].dm = '0;
        stg_d[6].ds = '0;
      end
    endcase
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NumStg-1];

  always_comb begin
    out_o.op   = stg_q[NumStg-1].op;
    out_o.unit = stg_q[NumStg-1].unit;
    out_o.dh   = stg_q[NumStg-1].dh;
    out_o.dm   = stg_q[NumStg-1].dm;
    out_o.ds   = stg_q[NumStg-1].ds;
  end

endmodule

### src/tdadj_core.sv
// time-of-day state and result register: mixed-radix add or subtract of
// the hour, minute and second deltas; uses tdadj_pkg
module tdadj_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tdadj_pkg::delta_t in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tdadj_pkg::out_t   out_o
);

  logic                        out_valid_q;
  logic [tdadj_pkg::HourW-1:0] hour_q, hour_d;
  logic [tdadj_pkg::MinW-1:0]  min_q, min_d;
  logic [tdadj_pkg::SecW-1:0]  sec_q, sec_d;
  logic                        bad_q, bad_d;
  logic                        load;

  logic [tdadj_pkg::HourW-1:0] dh;
  logic [tdadj_pkg::MinW-1:0]  dm;
  logic [tdadj_pkg::SecW-1:0]  ds;
  logic                        up;
  logic [tdadj_pkg::SecW:0]    s_sum, s_dif;
  logic [tdadj_pkg::MinW:0]    m_sum, m_dif;
  logic [tdadj_pkg::HourW:0]   h_sum, h_dif;
  logic [tdadj_pkg::SecW:0]    s_up, s_dn;
  logic [tdadj_pkg::MinW:0]    m_up, m_dn;
  logic [tdadj_pkg::HourW:0]   h_up, h_dn;
  logic                        s_cy, m_cy, s_bw, m_bw, h_bw;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    dh = in_i.dh;
    dm = in_i.dm;
    ds = in_i.ds;
    if (in_i.op inside {tdadj_pkg::OpInc, tdadj_pkg::OpDec}) begin
      dh = '0;
      dm = '0;
      ds = '0;
      case (in_i.unit)
        tdadj_pkg::UnitSec: ds = tdadj_pkg::SecW'(1);
        tdadj_pkg::UnitMin: dm = tdadj_pkg::MinW'(1);
        default:            dh = tdadj_pkg::HourW'(1);
      endcase
    end
    up = in_i.op inside {tdadj_pkg::OpInc, tdadj_pkg::OpAdd};

    // carry chain
    s_sum = {1'b0, sec_q} + {1'b0, ds};
    s_cy  = s_sum >= tdadj_pkg::SecWrap;
    s_up  = s_cy ? s_sum - tdadj_pkg::SecWrap : s_sum;
    m_sum = {1'b0, min_q} + {1'b0, dm} + (tdadj_pkg::MinW + 1)'(s_cy);
    m_cy  = m_sum >= tdadj_pkg::MinWrap;
    m_up  = m_cy ? m_sum - tdadj_pkg::MinWrap : m_sum;
    h_sum = {1'b0, hour_q} + {1'b0, dh} + (tdadj_pkg::HourW + 1)'(m_cy);
    h_up  = (h_sum >= tdadj_pkg::HourWrap) ? h_sum - tdadj_pkg::HourWrap : h_sum;

    // borrow chain
    s_dif = {1'b0, sec_q} - {1'b0, ds};
    s_bw  = s_dif[tdadj_pkg::SecW];
    s_dn  = s_bw ? s_dif + tdadj_pkg::SecWrap : s_dif;
    m_dif = {1'b0, min_q} - {1'b0, dm} - (tdadj_pkg::MinW + 1)'(s_bw);
    m_bw  = m_dif[tdadj_pkg::MinW];
    m_dn  = m_bw ? m_dif + tdadj_pkg::MinWrap : m_dif;
    h_dif = {1'b0, hour_q} - {1'b0, dh} - (tdadj_pkg::HourW + 1)'(m_bw);
    h_bw  = h_dif[tdadj_pkg::HourW];
    h_dn  = h_bw ? h_dif + tdadj_pkg::HourWrap : h_dif;

    if (in_i.unit == tdadj_pkg::UnitBad) begin
      hour_d = hour_q;
      min_d  = min_q;
      sec_d  = sec_q;
      bad_d  = 1'b1;
    end else if (up) begin
      hour_d = h_up[tdadj_pkg::HourW-1:0];
      min_d  = m_up[tdadj_pkg::MinW-1:0];
      sec_d  = s_up[tdadj_pkg::SecW-1:0];
      bad_d  = 1'b0;
    end else begin
      hour_d = h_dn[tdadj_pkg::HourW-1:0];
      min_d  = m_dn[tdadj_pkg::MinW-1:0];
      sec_d  = s_dn[tdadj_pkg::SecW-1:0];
      bad_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      hour_q      <= '0;
      min_q       <= '0;
      sec_q       <= '0;
      bad_q       <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      hour_q      <= hour_d;
      min_q       <= min_d;
      sec_q       <= sec_d;
      bad_q       <= bad_d;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_o.hours_now   = hour_q;
  assign out_o.minutes_now = min_q;
  assign out_o.seconds_now = sec_q;
  assign out_o.bad_unit    = bad_q;

endmodule

### src/time_of_day_adjust_unit.sv
// a result is valid once its transaction has passed the 7 split stages and the result register
// throughput: one transaction per cycle through a 7-stage constant-division pipeline,
// unless a stalled result backs it up; input stalls once all 7 stages are full
// reset: time 00:00:00, pipeline and result register empty
// top level; uses tdadj_pkg, tdadj_split and tdadj_core
module time_of_day_adjust_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tdadj_pkg::in_t  in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tdadj_pkg::out_t out_o
);

  logic              mid_valid;
  logic              mid_ready;
  tdadj_pkg::delta_t mid_delta;

  tdadj_split u_split (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .out_o       (mid_delta)
  );

  tdadj_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mid_valid),
    .in_ready_o  (mid_ready),
    .in_i        (mid_delta),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

### src/tdadj_chk.sv
// port-level checker for time_of_day_adjust_unit, bound to the top level
// uses tdadj_pkg and time_of_day_adjust_unit_defines.svh
`include "time_of_day_adjust_unit_defines.svh"

module tdadj_chk (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input tdadj_pkg::out_t out_o
);

  logic [tdadj_pkg::HourW-1:0] last_hour_q;
  logic [tdadj_pkg::MinW-1:0]  last_min_q;
  logic [tdadj_pkg::SecW-1:0]  last_sec_q;
  logic                        out_fire;
  logic                        time_in_range;
  logic                        time_held;

  assign out_fire = out_valid_o && out_ready_i;

  assign time_in_range = (out_o.hours_now <= 5'd23) && (out_o.minutes_now <= 6'd59) &&
                         (out_o.seconds_now <= 6'd59);
  assign time_held     = (out_o.hours_now == last_hour_q) && (out_o.minutes_now == last_min_q) &&
                         (out_o.seconds_now == last_sec_q);

  // time shown by the last delivered transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_hour_q <= '0;
      last_min_q  <= '0;
      last_sec_q  <= '0;
    end else if (out_fire) begin
      last_hour_q <= out_o.hours_now;
      last_min_q  <= out_o.minutes_now;
      last_sec_q  <= out_o.seconds_now;
    end
  end

  `TDADJ_ASSERT_IMP(a_time_range, out_valid_o, time_in_range, "time field out of range")
  `TDADJ_ASSERT_IMP(a_bad_unit_hold, out_fire && out_o.bad_unit, time_held, "invalid unit changed the time")
  `TDADJ_ASSERT_IMP(a_ready_when_empty, !out_valid_o, in_ready_o, "input stalled with empty output")
  `TDADJ_ASSERT_NXT(a_valid_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")
  `TDADJ_ASSERT_NXT(a_payload_hold, out_valid_o && !out_ready_i, $stable(out_o), "result changed")

endmodule

bind time_of_day_adjust_unit tdadj_chk u_tdadj_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);

### tb/tb_time_of_day_adjust_unit.sv
// self-checking testbench for time_of_day_adjust_unit: directed table, then random commands
// results are checked against table values or an in-bench time-of-day predictor, with random stalls on both sides
// depends on tdadj_pkg and the time_of_day_adjust_unit rtl
module tb_time_of_day_adjust_unit;

  localparam int unsigned DaySecs    = 86400;
  localparam int unsigned DayMins    = 1440;
  localparam int unsigned DayHours   = 24;
  localparam int unsigned RandCmds   = 1100;
  localparam int unsigned DrainAt    = 500;
  localparam int unsigned SettleCyc  = 20;
  localparam int unsigned CycleLimit = 600000;

  typedef struct {
    tdadj_pkg::in_t  cmd;
    bit              fixed;
    tdadj_pkg::out_t want;
  } cmd_row_t;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            cmd_valid = 1'b0;
  logic            cmd_ready;
  tdadj_pkg::in_t  cmd       = '0;
  logic            res_valid;
  logic            res_ready = 1'b0;
  tdadj_pkg::out_t res;

  logic [tdadj_pkg::HourW-1:0] hour_q   = '0;
  logic [tdadj_pkg::MinW-1:0]  minute_q = '0;
  logic [tdadj_pkg::SecW-1:0]  second_q = '0;

  tdadj_pkg::out_t pending_times[$];
  tdadj_pkg::out_t oldest_time;
  cmd_row_t        cmd_rows[$];
  int unsigned     mismatch_count = 0;
  int unsigned     cycle_count    = 0;
  int unsigned     ready_hold     = 0;

  time_of_day_adjust_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (cmd_valid),
    .in_ready_o  (cmd_ready),
    .in_i        (cmd),
    .out_valid_o (res_valid),
    .out_ready_i (res_ready),
    .out_o       (res)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic flag_mismatch(string msg);
    $display("error at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want) begin
      flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  function automatic tdadj_pkg::out_t hms(int unsigned h, int unsigned m, int unsigned s,
                                          bit bad);
    tdadj_pkg::out_t r;
    r.hours_now   = tdadj_pkg::HourW'(h);
    r.minutes_now = tdadj_pkg::MinW'(m);
    r.seconds_now = tdadj_pkg::SecW'(s);
    r.bad_unit    = bad;
    return r;
  endfunction

  function automatic tdadj_pkg::out_t advance_time(tdadj_pkg::in_t c);
    int unsigned span;
    int unsigned total;
    int unsigned delta;
    bit          up;
    bit          bad;
    bad = (c.unit == tdadj_pkg::UnitBad);
    if (!bad) begin
      up = (c.operation == tdadj_pkg::OpInc) || (c.operation == tdadj_pkg::OpAdd);
      case (c.unit)
        tdadj_pkg::UnitSec: begin
          span  = DaySecs;
          total = 32'(hour_q) * 3600 + 32'(minute_q) * 60 + 32'(second_q);
        end
        tdadj_pkg::UnitMin: begin
          span  = DayMins;
          total = 32'(hour_q) * 60 + 32'(minute_q);
        end
        default: begin
          span  = DayHours;
          total = 32'(hour_q);
        end
      endcase
      delta = ((c.operation == tdadj_pkg::OpInc) || (c.operation == tdadj_pkg::OpDec)) ?
              1 : 32'(c.amount) % span;
      total = up ? (total + delta) % span : (total + span - delta) % span;
      case (c.unit)
        tdadj_pkg::UnitSec: begin
          hour_q   = tdadj_pkg::HourW'(total / 3600);
          minute_q = tdadj_pkg::MinW'((total % 3600) / 60);
          second_q = tdadj_pkg::SecW'(total % 60);
        end
        tdadj_pkg::UnitMin: begin
          hour_q   = tdadj_pkg::HourW'(total / 60);
          minute_q = tdadj_pkg::MinW'(total % 60);
        end
        default: hour_q = tdadj_pkg::HourW'(total);
      endcase
    end
    return hms(32'(hour_q), 32'(minute_q), 32'(second_q), bad);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic tdadj_pkg::in_t random_cmd();
    tdadj_pkg::in_t c;
    int unsigned    span;
    c.operation = tdadj_pkg::op_e'($urandom_range(0, 3));
    c.unit      = ($urandom_range(0, 7) == 0) ? tdadj_pkg::UnitBad :
                  tdadj_pkg::unit_e'($urandom_range(0, 2));
    case (c.unit)
      tdadj_pkg::UnitSec: span = DaySecs;
      tdadj_pkg::UnitMin: span = DayMins;
      default:            span = DayHours;
    endcase
    case ($urandom_range(0, 3))
      0:       c.amount = tdadj_pkg::AmtW'($urandom_range(0, 100));
      1:       c.amount = tdadj_pkg::AmtW'(span - 2 + $urandom_range(0, 4));
      2:       c.amount = tdadj_pkg::AmtW'($urandom_range(0, 131071));
      default: c.amount = tdadj_pkg::AmtW'($urandom_range(0, span - 1));
    endcase
    return c;
  endfunction

  task automatic add_row(tdadj_pkg::op_e op, tdadj_pkg::unit_e unit, int unsigned amount,
                         bit fixed, tdadj_pkg::out_t want);
    cmd_row_t row;
    row.cmd.operation = op;
    row.cmd.unit      = unit;
    row.cmd.amount    = tdadj_pkg::AmtW'(amount);
    row.fixed         = fixed;
    row.want          = want;
    cmd_rows.push_back(row);
  endtask

  // one transaction on the command side; the prediction is made at acceptance
  task automatic drive_cmd(tdadj_pkg::in_t c, int unsigned gap, bit fixed,
                           tdadj_pkg::out_t want);
    tdadj_pkg::out_t predicted;
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (!cmd_ready);
    predicted = advance_time(c);
    pending_times.push_back(fixed ? want : predicted);
  endtask

  task automatic drain_results();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending_times.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (res_ready) begin
      if (pick_gap() > 0) begin
        res_ready  <= 1'b0;
        ready_hold <= pick_gap();
      end
    end else begin
      res_ready  <= 1'b1;
      ready_hold <= ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(0, 20);
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_valid && res_ready) begin
      if (pending_times.size() == 0) begin
        flag_mismatch("result transaction with nothing pending");
      end else begin
        oldest_time = pending_times.pop_front();
        check_field("hours_now", 32'(res.hours_now), 32'(oldest_time.hours_now));
        check_field("minutes_now", 32'(res.minutes_now), 32'(oldest_time.minutes_now));
        check_field("seconds_now", 32'(res.seconds_now), 32'(oldest_time.seconds_now));
        check_field("bad_unit", 32'(res.bad_unit), 32'(oldest_time.bad_unit));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("time_of_day_adjust_unit: mismatch");
      $finish;
    end
  end

  initial begin
    bit burst;
    add_row(tdadj_pkg::OpInc, tdadj_pkg::UnitSec,  0,      1, hms(0, 0, 1, 0));
    add_row(tdadj_pkg::OpDec, tdadj_pkg::UnitSec,  0,      1, hms(0, 0, 0, 0));
    add_row(tdadj_pkg::OpDec, tdadj_pkg::UnitSec,  131071, 1, hms(23, 59, 59, 0));
    add_row(tdadj_pkg::OpInc, tdadj_pkg::UnitSec,  0,      1, hms(0, 0, 0, 0));
    add_row(tdadj_pkg::OpDec, tdadj_pkg::UnitMin,  0,      1, hms(23, 59, 0, 0));
    add_row(tdadj_pkg::OpInc, tdadj_pkg::UnitMin,  0,      1, hms(0, 0, 0, 0));
    add_row(tdadj_pkg::OpDec, tdadj_pkg::UnitHour, 0,      1, hms(23, 0, 0, 0));
    add_row(tdadj_pkg::OpInc, tdadj_pkg::UnitHour, 0,      1, hms(0, 0, 0, 0));
    add_row(tdadj_pkg::OpAdd, tdadj_pkg::UnitSec,  86399,  1, hms(23, 59, 59, 0));
    add_row(tdadj_pkg::OpAdd, tdadj_pkg::UnitSec,  1,      1, hms(0, 0, 0, 0));
    add_row(tdadj_pkg::OpAdd, tdadj_pkg::UnitMin,  1439,   1, hms(23, 59, 0, 0));
    add_row(tdadj_pkg::OpSub, tdadj_pkg::UnitMin,  1439,   1, hms(0, 0, 0, 0));
    add_row(tdadj_pkg::OpAdd, tdadj_pkg::UnitHour, 23,     1, hms(23, 0, 0, 0));
    add_row(tdadj_pkg::OpSub, tdadj_pkg::UnitHour, 23,     1, hms(0, 0, 0, 0));
    add_row(tdadj_pkg::OpInc, tdadj_pkg::UnitBad,  131071, 1, hms(0, 0, 0, 1));
    add_row(tdadj_pkg::OpDec, tdadj_pkg::UnitBad,  0,      1, hms(0, 0, 0, 1));
    add_row(tdadj_pkg::OpAdd, tdadj_pkg::UnitBad,  131071, 1, hms(0, 0, 0, 1));
    add_row(tdadj_pkg::OpSub, tdadj_pkg::UnitBad,  131071, 1, hms(0, 0, 0, 1));
    add_row(tdadj_pkg::OpAdd, tdadj_pkg::UnitSec,  131071, 0, '0);
    add_row(tdadj_pkg::OpSub, tdadj_pkg::UnitMin,  131071, 0, '0);
    add_row(tdadj_pkg::OpAdd, tdadj_pkg::UnitMin,  131071, 0, '0);
    add_row(tdadj_pkg::OpSub, tdadj_pkg::UnitHour, 131071, 0, '0);
    add_row(tdadj_pkg::OpAdd, tdadj_pkg::UnitHour, 0,      0, '0);
    add_row(tdadj_pkg::OpSub, tdadj_pkg::UnitSec,  86400,  0, '0);
    add_row(tdadj_pkg::OpInc, tdadj_pkg::UnitSec,  131071, 0, '0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (cmd_rows[i]) begin
      drive_cmd(cmd_rows[i].cmd, pick_gap(), cmd_rows[i].fixed, cmd_rows[i].want);
    end
    drain_results();

    burst = 1'b0;
    for (int unsigned n = 0; n < RandCmds; n++) begin
      if (n % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      if (n == DrainAt) drain_results();
      drive_cmd(random_cmd(), burst ? 0 : pick_gap(), 1'b0, '0);
    end

    cmd_valid <= 1'b0;
    while (pending_times.size() != 0) @(posedge clk);
    repeat (SettleCyc) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("time_of_day_adjust_unit: match");
    end else begin
      $display("time_of_day_adjust_unit: mismatch");
    end
    $finish;
  end

endmodule
